[rtl/vertex_falloff_translate_top_macros.svh]
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef VERTEX_FALLOFF_TRANSLATE_TOP_MACROS_SVH
`define VERTEX_FALLOFF_TRANSLATE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VFT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/vft_pkg.sv]
`timescale 1ns / 1ps

package vft_pkg;

    // Coordinate and fixed point formats.
    localparam int COORD_W    = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PAINT_W    = 16;
    localparam int RADIUS_W   = 32;
    localparam int GAIN_W     = 24;
    localparam int GAIN_FRAC  = 16;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int DIST_W     = COORD_W;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int UNIT_W     = FRAC_BITS + 1;
    localparam int CFG_IDX_W  = 3;

    localparam logic [UNIT_W-1:0]  ONE_F     = UNIT_W'(1) << FRAC_BITS;
    localparam logic [UNIT_W:0]    THREE_ONE = (UNIT_W + 1)'(3) << FRAC_BITS;
    localparam logic [PAINT_W-1:0] PAINT_ONE = PAINT_W'(32768);

    typedef logic signed [COORD_W-1:0] coord_t;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_X = 3'd0,
        REG_TARGET_Y = 3'd1,
        REG_TARGET_Z = 3'd2,
        REG_SHIFT_X  = 3'd3,
        REG_SHIFT_Y  = 3'd4,
        REG_SHIFT_Z  = 3'd5,
        REG_INV_RAD  = 3'd6,
        REG_GAIN     = 3'd7
    } reg_idx_t;

    // One vertex as it travels down the pipeline.
    typedef struct packed {
        coord_t [2:0]       pos;
        logic [PAINT_W-1:0] paint;
    } vtx_t;

    // Configuration register file.
    typedef struct packed {
        coord_t [2:0]        target;
        coord_t [2:0]        shift;
        logic [RADIUS_W-1:0] inv_radius;
        logic [GAIN_W-1:0]   gain;
    } cfg_t;

endpackage

[rtl/vft_intf.sv]
`timescale 1ns / 1ps

// Vertex input channel.
interface vft_in_if;
    import vft_pkg::*;
    logic               valid;
    logic               ready;
    coord_t             pos_x;
    coord_t             pos_y;
    coord_t             pos_z;
    logic [PAINT_W-1:0] paint_weight;

    modport source (output valid, pos_x, pos_y, pos_z, paint_weight, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, paint_weight, output ready);
endinterface

// Result channel.
interface vft_out_if;
    import vft_pkg::*;
    logic   valid;
    logic   ready;
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   moved;

    modport source (output valid, out_x, out_y, out_z, moved, input ready);
    modport sink   (input valid, out_x, out_y, out_z, moved, output ready);
endinterface

// Configuration write channel.
interface vft_cfg_if;
    import vft_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COORD_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/vft_dist.sv]
`timescale 1ns / 1ps

module vft_dist
    import vft_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  vtx_t            in_vtx,
    input  coord_t [2:0]    target,
    output logic            out_valid,
    input  logic            out_ready,
    output vtx_t            out_vtx,
    output logic [SQ_W-1:0] out_sum
);

    localparam int NS = 3;

    logic [NS-1:0]          valid_reg;
    logic [NS-1:0]          en;
    vtx_t                   vtx_reg [NS];
    logic [2:0][COORD_W-1:0] mag_reg, mag_next;
    logic [2:0][SQ_W-1:0]   sq_reg, sq_next;
    logic [SQ_W-1:0]        sum_reg, sum_next;
    vtx_t                   vtx_next;

    // A stage loads when it is empty or its item moves on.
    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NS-1];
    assign out_vtx   = vtx_reg[NS-1];
    assign out_sum   = sum_reg;

    // Stage 1: coordinate differences and their magnitudes; clamp the paint weight.
    always_comb
    begin
        logic [COORD_W:0] diff;
        logic [COORD_W:0] mag;
        vtx_next = in_vtx;
        if (in_vtx.paint > PAINT_ONE)
        begin
            vtx_next.paint = PAINT_ONE;
        end
        for (int i = 0; i < 3; i++)
        begin
            diff = {in_vtx.pos[i][COORD_W-1], in_vtx.pos[i]}
                 - {target[i][COORD_W-1], target[i]};
            mag  = diff[COORD_W] ? (~diff + 1'b1) : diff;
            mag_next[i] = mag[COORD_W] ? {COORD_W{1'b1}} : mag[COORD_W-1:0];
        end
    end

    // Stage 2: squares.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = SQ_W'(mag_reg[i]) * SQ_W'(mag_reg[i]);
        end
    end

    // Stage 3: saturating sum of squares.
    always_comb
    begin
        logic [SQ_W+1:0] total;
        total = (SQ_W + 2)'(sq_reg[0]) + (SQ_W + 2)'(sq_reg[1]) + (SQ_W + 2)'(sq_reg[2]);
        sum_next = (total[SQ_W+1:SQ_W] != 2'b00) ? {SQ_W{1'b1}} : total[SQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0]) valid_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                if (en[k]) valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            vtx_reg[0] <= vtx_next;
            mag_reg    <= mag_next;
        end
        if (en[1])
        begin
            vtx_reg[1] <= vtx_reg[0];
            sq_reg     <= sq_next;
        end
        if (en[2])
        begin
            vtx_reg[2] <= vtx_reg[1];
            sum_reg    <= sum_next;
        end
    end

endmodule

[rtl/vft_sqrt.sv]
`timescale 1ns / 1ps

module vft_sqrt
    import vft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  vtx_t              in_vtx,
    input  logic [SQ_W-1:0]   in_sum,
    output logic              out_valid,
    input  logic              out_ready,
    output vtx_t              out_vtx,
    output logic [DIST_W-1:0] out_dist
);

    localparam int LAST = SQRT_STEPS - 1;

    logic [SQRT_STEPS-1:0] valid_reg;
    logic [SQRT_STEPS-1:0] en;
    vtx_t                  vtx_reg  [SQRT_STEPS];
    logic [SQ_W-1:0]       rem_reg  [SQRT_STEPS];
    logic [SQ_W-1:0]       root_reg [SQRT_STEPS];

    assign in_ready  = en[0];
    assign out_valid = valid_reg[LAST];
    assign out_vtx   = vtx_reg[LAST];
    assign out_dist  = root_reg[LAST][DIST_W-1:0];

    // One result bit per stage, from the most significant down.
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);

        logic            valid_src;
        vtx_t            vtx_src;
        logic [SQ_W-1:0] rem_src, root_src, trial;
        logic [SQ_W-1:0] rem_next, root_next;

        if (k == 0)
        begin : g_first
            assign valid_src = in_valid;
            assign vtx_src   = in_vtx;
            assign rem_src   = in_sum;
            assign root_src  = '0;
        end
        else
        begin : g_rest
            assign valid_src = valid_reg[k-1];
            assign vtx_src   = vtx_reg[k-1];
            assign rem_src   = rem_reg[k-1];
            assign root_src  = root_reg[k-1];
        end

        if (k == LAST)
        begin : g_en_last
            assign en[k] = !valid_reg[k] || out_ready;
        end
        else
        begin : g_en_mid
            assign en[k] = !valid_reg[k] || en[k+1];
        end

        // Trial subtraction of the current root plus this bit.
        always_comb
        begin
            trial = root_src + STEP_BIT;
            if (rem_src >= trial)
            begin
                rem_next  = rem_src - trial;
                root_next = (root_src >> 1) + STEP_BIT;
            end
            else
            begin
                rem_next  = rem_src;
                root_next = root_src >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                valid_reg[k] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                vtx_reg[k]  <= vtx_src;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

endmodule

[rtl/vft_weight.sv]
`timescale 1ns / 1ps

module vft_weight
    import vft_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vtx_t                in_vtx,
    input  logic [DIST_W-1:0]   in_dist,
    input  logic [RADIUS_W-1:0] inv_radius,
    input  logic [GAIN_W-1:0]   gain,
    output logic                out_valid,
    input  logic                out_ready,
    output vtx_t                out_vtx,
    output logic [PAINT_W-1:0]  out_weight,
    output logic                out_moved
);

    localparam int NS     = 6;
    localparam int PROD_W = DIST_W + RADIUS_W;
    localparam int FP_W   = 2 * UNIT_W + 1;
    localparam int CP_W   = UNIT_W + GAIN_W;
    localparam int WP_W   = UNIT_W + PAINT_W;

    logic [NS-1:0]       valid_reg;
    logic [NS-1:0]       en;
    vtx_t                vtx_reg [NS];
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [UNIT_W-1:0]   t_reg, t_next;
    logic [UNIT_W-1:0]   t2_reg;
    logic [UNIT_W-1:0]   s_reg, s_next;
    logic [UNIT_W-1:0]   f_reg, f_next;
    logic [UNIT_W-1:0]   c_reg, c_next;
    logic                fnz_reg;
    logic [PAINT_W-1:0]  w_reg, w_next;
    logic                moved_reg, moved_next;

    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready   = en[0];
    assign out_valid  = valid_reg[NS-1];
    assign out_vtx    = vtx_reg[NS-1];
    assign out_weight = w_reg;
    assign out_moved  = moved_reg;

    // Falloff arithmetic, at most one multiply per stage.
    always_comb
    begin
        logic [PROD_W-FRAC_BITS-1:0] scaled;
        logic [2*UNIT_W-1:0]         tt;
        logic [UNIT_W:0]             fac;
        logic [FP_W-1:0]             fp;
        logic [CP_W-1:0]             cp;
        logic [CP_W-GAIN_FRAC-1:0]   cs;
        logic [WP_W-1:0]             wp;

        // Distance times reciprocal radius.
        prod_next = PROD_W'(in_dist) * PROD_W'(inv_radius);

        // t = 1 - scaled distance, clamped at zero.
        scaled = prod_reg[PROD_W-1:FRAC_BITS];
        t_next = (scaled >= (PROD_W - FRAC_BITS)'(ONE_F)) ? '0
                 : ONE_F - scaled[UNIT_W-1:0];

        // t squared.
        tt     = (2 * UNIT_W)'(t_reg) * (2 * UNIT_W)'(t_reg);
        s_next = tt[FRAC_BITS+UNIT_W-1:FRAC_BITS];

        // Smoothstep: t^2 * (3 - 2t).
        fac    = THREE_ONE - {t2_reg, 1'b0};
        fp     = FP_W'(s_reg) * FP_W'(fac);
        f_next = fp[FRAC_BITS+UNIT_W-1:FRAC_BITS];

        // Gain, clamped to one.
        cp     = CP_W'(f_reg) * CP_W'(gain);
        cs     = cp[CP_W-1:GAIN_FRAC];
        c_next = (cs > (CP_W - GAIN_FRAC)'(ONE_F)) ? ONE_F : cs[UNIT_W-1:0];

        // Paint weight, result in Q1.15.
        wp         = WP_W'(c_reg) * WP_W'(vtx_reg[4].paint);
        w_next     = wp[FRAC_BITS+PAINT_W-1:FRAC_BITS];
        moved_next = (vtx_reg[4].paint != '0) && fnz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0]) valid_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                if (en[k]) valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            vtx_reg[0] <= in_vtx;
            prod_reg   <= prod_next;
        end
        if (en[1])
        begin
            vtx_reg[1] <= vtx_reg[0];
            t_reg      <= t_next;
        end
        if (en[2])
        begin
            vtx_reg[2] <= vtx_reg[1];
            s_reg      <= s_next;
            t2_reg     <= t_reg;
        end
        if (en[3])
        begin
            vtx_reg[3] <= vtx_reg[2];
            f_reg      <= f_next;
        end
        if (en[4])
        begin
            vtx_reg[4] <= vtx_reg[3];
            c_reg      <= c_next;
            fnz_reg    <= (f_reg != '0);
        end
        if (en[5])
        begin
            vtx_reg[5] <= vtx_reg[4];
            w_reg      <= w_next;
            moved_reg  <= moved_next;
        end
    end

endmodule

[rtl/vft_apply.sv]
`timescale 1ns / 1ps

module vft_apply
    import vft_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vtx_t               in_vtx,
    input  logic [PAINT_W-1:0] in_weight,
    input  logic               in_moved,
    input  coord_t [2:0]       shift,
    output logic               out_valid,
    input  logic               out_ready,
    output coord_t [2:0]       out_pos,
    output logic               out_moved
);

    localparam int NS     = 2;
    localparam int OFF_W  = COORD_W + PAINT_W;
    localparam int SUM_W  = COORD_W + 2;
    localparam int ROUND  = PAINT_W - 1;

    logic [NS-1:0]            valid_reg;
    logic [NS-1:0]            en;
    vtx_t                     vtx_reg;
    logic                     moved_a_reg;
    logic [2:0][COORD_W-1:0]  off_reg, off_next;
    logic [2:0]               neg_reg, neg_next;
    coord_t [2:0]             pos_reg, pos_next;
    logic                     moved_reg;

    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || out_ready;
        en[0]    = !valid_reg[0] || en[1];
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NS-1];
    assign out_pos   = pos_reg;
    assign out_moved = moved_reg;

    // Offset magnitude: |shift| times weight, rounded half away from zero.
    always_comb
    begin
        logic [COORD_W-1:0] mag;
        logic [OFF_W-1:0]   prod;
        for (int i = 0; i < 3; i++)
        begin
            neg_next[i] = shift[i][COORD_W-1];
            mag  = neg_next[i] ? (~shift[i] + 1'b1) : shift[i];
            prod = OFF_W'(mag) * OFF_W'(in_weight) + (OFF_W'(1) << (ROUND - 1));
            off_next[i] = prod[ROUND+COORD_W-1:ROUND];
        end
    end

    // Apply the offset with saturation, or pass the position through.
    always_comb
    begin
        logic [SUM_W-1:0] base;
        logic [SUM_W-1:0] r;
        for (int i = 0; i < 3; i++)
        begin
            base = {{2{vtx_reg.pos[i][COORD_W-1]}}, vtx_reg.pos[i]};
            r    = neg_reg[i] ? base - SUM_W'(off_reg[i]) : base + SUM_W'(off_reg[i]);
            if (!moved_a_reg)
            begin
                pos_next[i] = vtx_reg.pos[i];
            end
            else if (r[SUM_W-1:COORD_W-1] == '0 || r[SUM_W-1:COORD_W-1] == '1)
            begin
                pos_next[i] = r[COORD_W-1:0];
            end
            else
            begin
                pos_next[i] = r[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                         : {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0]) valid_reg[0] <= in_valid;
            if (en[1]) valid_reg[1] <= valid_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            vtx_reg     <= in_vtx;
            moved_a_reg <= in_moved;
            off_reg     <= off_next;
            neg_reg     <= neg_next;
        end
        if (en[1])
        begin
            pos_reg   <= pos_next;
            moved_reg <= moved_a_reg;
        end
    end

endmodule

[rtl/vertex_falloff_translate_top.sv]
`timescale 1ns / 1ps

// Vertex falloff translate: moves each vertex along the shift vector, scaled by a
// smoothstep falloff of its distance to the target point and by its paint weight.
// The datapath is a 43-stage pipeline that takes one vertex per clock unless input is
// blocked: 3 stages form the squared distance, 32 stages take the square root one result
// bit each, 6 stages form the weight one multiply at a time, and 2 stages apply the
// offset and hold the result. A stalled output only blocks input once every stage is
// full. Configuration writes are always ready and take effect in the next cycle.
module vertex_falloff_translate_top
    import vft_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    vft_in_if.sink    in_ch,
    vft_out_if.source out_ch,
    vft_cfg_if.sink   cfg
);

    cfg_t cfg_reg;

    logic              d_valid, d_ready;
    vtx_t              d_vtx;
    logic [SQ_W-1:0]   d_sum;
    logic              q_valid, q_ready;
    vtx_t              q_vtx;
    logic [DIST_W-1:0] q_dist;
    logic              w_valid, w_ready;
    vtx_t              w_vtx;
    logic [PAINT_W-1:0] w_weight;
    logic              w_moved;
    coord_t [2:0]      res_pos;
    vtx_t              in_vtx;

    // Configuration register file.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target     <= '0;
            cfg_reg.shift      <= '0;
            cfg_reg.inv_radius <= RADIUS_W'(13107);
            cfg_reg.gain       <= GAIN_W'(65536);
        end
        else if (cfg.valid)
        begin
            case (reg_idx_t'(cfg.index))
                REG_TARGET_X: cfg_reg.target[0]  <= cfg.data;
                REG_TARGET_Y: cfg_reg.target[1]  <= cfg.data;
                REG_TARGET_Z: cfg_reg.target[2]  <= cfg.data;
                REG_SHIFT_X:  cfg_reg.shift[0]   <= cfg.data;
                REG_SHIFT_Y:  cfg_reg.shift[1]   <= cfg.data;
                REG_SHIFT_Z:  cfg_reg.shift[2]   <= cfg.data;
                REG_INV_RAD:  cfg_reg.inv_radius <= cfg.data[RADIUS_W-1:0];
                REG_GAIN:     cfg_reg.gain       <= cfg.data[GAIN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Pack the incoming item.
    assign in_vtx.pos[0] = in_ch.pos_x;
    assign in_vtx.pos[1] = in_ch.pos_y;
    assign in_vtx.pos[2] = in_ch.pos_z;
    assign in_vtx.paint  = in_ch.paint_weight;

    vft_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_vtx    (in_vtx),
        .target    (cfg_reg.target),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_vtx   (d_vtx),
        .out_sum   (d_sum)
    );

    vft_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_vtx    (d_vtx),
        .in_sum    (d_sum),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_vtx   (q_vtx),
        .out_dist  (q_dist)
    );

    vft_weight u_weight (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_vtx     (q_vtx),
        .in_dist    (q_dist),
        .inv_radius (cfg_reg.inv_radius),
        .gain       (cfg_reg.gain),
        .out_valid  (w_valid),
        .out_ready  (w_ready),
        .out_vtx    (w_vtx),
        .out_weight (w_weight),
        .out_moved  (w_moved)
    );

    vft_apply u_apply (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (w_valid),
        .in_ready  (w_ready),
        .in_vtx    (w_vtx),
        .in_weight (w_weight),
        .in_moved  (w_moved),
        .shift     (cfg_reg.shift),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_pos   (res_pos),
        .out_moved (out_ch.moved)
    );

    assign out_ch.out_x = res_pos[0];
    assign out_ch.out_y = res_pos[1];
    assign out_ch.out_z = res_pos[2];

endmodule

[rtl/vft_checker.sv]
`timescale 1ns / 1ps
`include "vertex_falloff_translate_top_macros.svh"

module vft_checker
    import vft_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input coord_t out_x,
    input coord_t out_y,
    input coord_t out_z,
    input logic   moved,
    input logic   cfg_ready
);

    // A stalled result keeps its valid and its payload.
    `VFT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(moved), "stalled result changed")

    // Input is refused only when the whole pipeline is full behind a stalled output.
    `VFT_ASSERT_SAME(a_in_block, !in_ready, out_valid && !out_ready, "input blocked with room in the pipeline")

    // The configuration port never stalls.
    `VFT_ASSERT_SAME(a_cfg_ready, 1'b1, cfg_ready, "configuration port not ready")

endmodule

bind vertex_falloff_translate_top vft_checker u_vft_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_x     (out_ch.out_x),
    .out_y     (out_ch.out_y),
    .out_z     (out_ch.out_z),
    .moved     (out_ch.moved),
    .cfg_ready (cfg.ready)
);
